[hdl/pngu_pkg.sv]
`default_nettype none
package pngu_pkg;

	localparam int MAX_ROW_BYTES_DEF = 16384;
	localparam int MAX_ROWS_DEF      = 4096;
	localparam int NUM_FILT          = 5;

	typedef enum logic [2:0] {
		FILT_NONE  = 3'd0,
		FILT_SUB   = 3'd1,
		FILT_UP    = 3'd2,
		FILT_AVG   = 3'd3,
		FILT_PAETH = 3'd4
	} filt_t;

	typedef enum logic [1:0] {
		REG_ROW_BYTES = 2'd0,
		REG_BPP       = 2'd1,
		REG_ROW_COUNT = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic  is_data;
		logic  emit;
		logic  row_end;
		logic  image_end;
		logic  bad;
		logic  have_above;
		logic  have_left;
		filt_t filt;
	} pngu_ctl_t;

endpackage
`default_nettype wire

[hdl/pngu_ram.sv]
`default_nettype none
module pngu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16384
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[hdl/pngu_recon.sv]
`default_nettype none
module pngu_recon (
	input  wire logic                 [7:0] raw,
	input  wire pngu_pkg::pngu_ctl_t        ctl,
	input  wire logic                 [7:0] left_byte,
	input  wire logic                 [7:0] above_byte,
	input  wire logic                 [7:0] upleft_byte,
	output logic                      [7:0] val,
	output logic                      [7:0] b_used
);
	import pngu_pkg::*;

	logic [7:0] a;
	logic [7:0] b;
	logic [7:0] c;
	logic [8:0] sum_ab;
	logic [8:0] c2;
	logic [7:0] pa;
	logic [7:0] pb;
	logic [8:0] pc;
	logic [7:0] paeth;
	logic [7:0] pred;

	always_comb begin
		a      = ctl.have_left ? left_byte : 8'd0;
		b      = ctl.have_above ? above_byte : 8'd0;
		c      = (ctl.have_left && ctl.have_above) ? upleft_byte : 8'd0;
		sum_ab = {1'b0, a} + {1'b0, b};
		c2     = {c, 1'b0};
		// distances of a+b-c to a, b and c
		pa     = (b > c) ? b - c : c - b;
		pb     = (a > c) ? a - c : c - a;
		pc     = (sum_ab > c2) ? sum_ab - c2 : c2 - sum_ab;
		priority if (({1'b0, pa} <= {1'b0, pb}) && ({1'b0, pa} <= pc)) begin
			paeth = a;
		end else if ({1'b0, pb} <= pc) begin
			paeth = b;
		end else begin
			paeth = c;
		end
		unique case (ctl.filt)
			FILT_SUB:   pred = a;
			FILT_UP:    pred = b;
			FILT_AVG:   pred = sum_ab[8:1];
			FILT_PAETH: pred = paeth;
			default:    pred = 8'd0;
		endcase
		val    = raw + pred;
		b_used = b;
	end

endmodule
`default_nettype wire

[hdl/png_scanline_unfilter.sv]
`default_nettype none
// PNG scanline unfilter: takes the inflated image stream one byte per cycle
// while the output is not stalled (a filter-type byte, then row_bytes data
// bytes, for each of row_count rows) and returns each reconstructed data
// byte as one output item, with tlast on the last byte of a row and tuser[0]
// on the last byte of the image. Filter bytes give no output; a filter type
// above 4 gives one item with tuser[1] set and data zero, and the rest of
// that image is consumed silently. The previous row lives in a
// single-port-read line buffer that is read at the cycle a byte is accepted
// and written back from the reconstruction stage. Any write to a mapped
// register restarts the image; write registers only while idle.
module png_scanline_unfilter #(
	parameter int MAX_ROW_BYTES = pngu_pkg::MAX_ROW_BYTES_DEF,
	parameter int MAX_ROWS      = pngu_pkg::MAX_ROWS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] raw_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [7:0]  m_axis_tdata,   // [7:0] pixel_byte
	output logic             m_axis_tlast,   // row_end
	output logic      [1:0]  m_axis_tuser,   // [0] image_end, [1] bad_filter
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	import pngu_pkg::*;

	localparam int COL_W = $clog2(MAX_ROW_BYTES);
	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	// config
	logic [14:0] row_bytes_q;
	logic [2:0]  bpp_q;
	logic [12:0] row_count_q;
	logic        cfg_wr;
	logic        cfg_restart;
	reg_idx_t    cfg_idx;

	// control state
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	filt_t            filt_q;
	logic             awaiting_q;
	logic             failed_q;

	logic [COL_W-1:0] rb_last;
	logic [ROW_W-1:0] rc_last;
	logic [1:0]       bpp_idx;

	logic             accept;
	logic             last_col;
	logic             last_row;
	pngu_ctl_t        ctl_in;

	// stage 1
	logic             s1_valid_q;
	logic [7:0]       raw_s1;
	logic [COL_W-1:0] col_s1;
	pngu_ctl_t        ctl_s1;
	logic             s1_go;

	logic [7:0]       left_q [4];
	logic [7:0]       upl_q  [4];
	logic [7:0]       above_rd;
	logic [7:0]       val;
	logic [7:0]       b_used;

	logic             out_valid_q;
	logic [7:0]       out_data_q;
	logic             out_last_q;
	logic [1:0]       out_user_q;

	// ---------------- configuration port ----------------
	assign pready      = 1'b1;
	assign cfg_idx     = reg_idx_t'(paddr[3:2]);
	assign cfg_wr      = psel && penable && pwrite && pready;
	assign cfg_restart = cfg_wr && (cfg_idx == REG_ROW_BYTES || cfg_idx == REG_BPP ||
		cfg_idx == REG_ROW_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q <= 15'd4;
			bpp_q       <= 3'd4;
			row_count_q <= 13'd1;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_ROW_BYTES: row_bytes_q <= pwdata[14:0];
				REG_BPP:       bpp_q       <= pwdata[2:0];
				REG_ROW_COUNT: row_count_q <= pwdata[12:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_ROW_BYTES: prdata = {17'd0, row_bytes_q};
			REG_BPP:       prdata = {29'd0, bpp_q};
			REG_ROW_COUNT: prdata = {19'd0, row_count_q};
			default:       prdata = 32'd0;
		endcase
	end

	// effective (clamped) geometry
	always_comb begin
		if (row_bytes_q == 15'd0) begin
			rb_last = '0;
		end else if (32'(row_bytes_q) > 32'(MAX_ROW_BYTES)) begin
			rb_last = COL_W'(MAX_ROW_BYTES - 1);
		end else begin
			rb_last = COL_W'(row_bytes_q - 15'd1);
		end
		if (row_count_q == 13'd0) begin
			rc_last = '0;
		end else if (32'(row_count_q) > 32'(MAX_ROWS)) begin
			rc_last = ROW_W'(MAX_ROWS - 1);
		end else begin
			rc_last = ROW_W'(row_count_q - 13'd1);
		end
		if (bpp_q == 3'd0) begin
			bpp_idx = 2'd0;
		end else if (bpp_q > 3'd4) begin
			bpp_idx = 2'd3;
		end else begin
			bpp_idx = 2'(bpp_q - 3'd1);
		end
	end

	// ---------------- input side ----------------
	assign s1_go         = s1_valid_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || s1_go;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign last_col      = (col_q == rb_last);
	assign last_row      = (row_q == rc_last);

	always_comb begin
		ctl_in            = '0;
		ctl_in.filt       = filt_q;
		ctl_in.have_above = (row_q != '0);
		ctl_in.have_left  = (32'(col_q) > 32'(bpp_idx));
		if (awaiting_q) begin
			ctl_in.bad  = !failed_q && (s_axis_tdata > 8'(NUM_FILT - 1));
			ctl_in.emit = ctl_in.bad;
		end else begin
			ctl_in.is_data   = 1'b1;
			ctl_in.emit      = !failed_q;
			ctl_in.row_end   = last_col;
			ctl_in.image_end = last_col && last_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			filt_q     <= FILT_NONE;
			awaiting_q <= 1'b1;
			failed_q   <= 1'b0;
		end else if (cfg_restart) begin
			col_q      <= '0;
			row_q      <= '0;
			filt_q     <= FILT_NONE;
			awaiting_q <= 1'b1;
			failed_q   <= 1'b0;
		end else if (accept) begin
			if (awaiting_q) begin
				awaiting_q <= 1'b0;
				col_q      <= '0;
				if (ctl_in.bad) begin
					failed_q <= 1'b1;
				end else if (!failed_q) begin
					filt_q <= filt_t'(s_axis_tdata[2:0]);
				end
			end else if (last_col) begin
				awaiting_q <= 1'b1;
				col_q      <= '0;
				if (last_row) begin
					row_q    <= '0;
					filt_q   <= FILT_NONE;
					failed_q <= 1'b0;
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// ---------------- line buffer ----------------
	pngu_ram #(
		.WIDTH (8),
		.DEPTH (MAX_ROW_BYTES)
	) u_line (
		.clk   (clk),
		.we    (s1_go && ctl_s1.is_data),
		.waddr (col_s1),
		.wdata (val),
		.re    (accept && !awaiting_q),
		.raddr (col_q),
		.rdata (above_rd)
	);

	// ---------------- stage 1: reconstruction ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			raw_s1 <= s_axis_tdata;
			col_s1 <= col_q;
			ctl_s1 <= ctl_in;
		end
	end

	pngu_recon u_recon (
		.raw         (raw_s1),
		.ctl         (ctl_s1),
		.left_byte   (left_q[bpp_idx]),
		.above_byte  (above_rd),
		.upleft_byte (upl_q[bpp_idx]),
		.val         (val),
		.b_used      (b_used)
	);

	// history of this row; stale entries are masked by have_left
	always_ff @(posedge clk) begin
		if (s1_go && ctl_s1.is_data) begin
			left_q[0] <= val;
			upl_q[0]  <= b_used;
			for (int i = 1; i < 4; i++) begin
				left_q[i] <= left_q[i-1];
				upl_q[i]  <= upl_q[i-1];
			end
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && ctl_s1.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && ctl_s1.emit) begin
			out_data_q <= ctl_s1.bad ? 8'd0 : val;
			out_last_q <= ctl_s1.row_end;
			out_user_q <= {ctl_s1.bad, ctl_s1.image_end};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_user_q;

	// ---------------- assertions ----------------
	a_image_end_is_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
		else $error("image end without row end");

	a_line_rd_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_go |=> $stable(above_rd))
		else $error("line buffer data changed under a stalled byte");

	a_filter_col_zero: assert property (@(posedge clk) disable iff (!arst_n)
		awaiting_q |-> col_q == '0)
		else $error("column not at zero while waiting for a filter byte");

	a_bad_no_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tlast && !m_axis_tuser[0] &&
			m_axis_tdata == 8'd0)
		else $error("error item carries row or image end");

endmodule
`default_nettype wire

[verif/png_scanline_unfilter_test.sv]
`default_nettype none
module png_scanline_unfilter_test;
	timeunit 1ns;
	timeprecision 1ps;
	import pngu_pkg::*;

	localparam int RESET_CYCLES  = 12;
	localparam int DRAIN_CYCLES  = 8;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int MAX_PRINTS    = 30;
	localparam int HOLD_CYCLES   = 400;
	localparam int EXTREME_ITEMS = 150;
	localparam logic [1:0] REG_UNUSED   = 2'd3;
	localparam logic [7:0] FILT_BAD_LOW = 8'd5;
	localparam logic [7:0] FILT_BAD_TOP = 8'hFF;

	typedef struct packed {
		logic [7:0] pixel;
		logic       row_end;
		logic       image_end;
		logic       bad;
	} pixel_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] raw_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;           // [7:0] pixel_byte
	logic        m_axis_tlast;           // row_end
	logic [1:0]  m_axis_tuser;           // [0] image_end, [1] bad_filter
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = 4'h0;
	logic [31:0] pwdata = 32'h0;
	logic [31:0] prdata;
	logic        pready;

	png_scanline_unfilter i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// unfilter state as the block should hold it
	logic [14:0] cfg_row_bytes;
	logic [2:0]  cfg_bpp;
	logic [12:0] cfg_row_count;
	logic [7:0]  prev_row [MAX_ROW_BYTES_DEF];
	logic [7:0]  left_px [4];
	logic [7:0]  upleft_px [4];
	int unsigned col_pos;
	int unsigned row_pos;
	filt_t       row_filt;
	bit          want_filter;
	bit          image_bad;

	pixel_out_t  pending_pixels [$];
	pixel_out_t  head_px;
	int          errors = 0;
	int          cycles = 0;
	int          sent_items = 0;
	int          src_idle_pct = 0;
	int          snk_stall_pct = 0;
	int          hold_reqs = 0;
	int          hold_seen = 0;
	int          hold_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("** png_scanline_unfilter: FAILED **");
			$finish;
		end
	end

	// output side: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen     <= hold_reqs;
			hold_left     <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
		if (v == 0)
			return 1;
		return (v > hi) ? hi : v;
	endfunction

	function automatic logic [7:0] paeth_choose(logic [7:0] a, logic [7:0] b, logic [7:0] c);
		int ai, bi, ci, p, da, db, dc;
		ai = a;
		bi = b;
		ci = c;
		p  = ai + bi - ci;
		da = (p > ai) ? p - ai : ai - p;
		db = (p > bi) ? p - bi : bi - p;
		dc = (p > ci) ? p - ci : ci - p;
		if (da <= db && da <= dc)
			return a;
		if (db <= dc)
			return b;
		return c;
	endfunction

	task automatic restart_image();
		left_px     = '{default: 8'h00};
		upleft_px   = '{default: 8'h00};
		col_pos     = 0;
		row_pos     = 0;
		row_filt    = FILT_NONE;
		want_filter = 1'b1;
		image_bad   = 1'b0;
	endtask

	task automatic config_write(logic [1:0] idx, logic [31:0] data);
		case (idx)
			REG_ROW_BYTES: cfg_row_bytes = data[14:0];
			REG_BPP:       cfg_bpp = data[2:0];
			REG_ROW_COUNT: cfg_row_count = data[12:0];
			default:       return;
		endcase
		restart_image();
	endtask

	// one accepted byte: update state, queue the pixel it yields, if any
	task automatic unfilter_byte(logic [7:0] raw);
		int unsigned rb, bpp, rc, col;
		int          sum;
		logic [7:0]  a, b, c, val;
		bit          have_above, have_left, last_row;
		rb  = clamp_reg(cfg_row_bytes, MAX_ROW_BYTES_DEF);
		bpp = clamp_reg(cfg_bpp, 4);
		rc  = clamp_reg(cfg_row_count, MAX_ROWS_DEF);
		if (want_filter) begin
			want_filter = 1'b0;
			col_pos     = 0;
			left_px     = '{default: 8'h00};
			upleft_px   = '{default: 8'h00};
			if (image_bad)
				return;
			if (raw > 8'(FILT_PAETH)) begin
				image_bad = 1'b1;
				pending_pixels.push_back('{pixel: 8'h00, row_end: 1'b0, image_end: 1'b0,
					bad: 1'b1});
				return;
			end
			row_filt = filt_t'(raw[2:0]);
			return;
		end
		col = (col_pos >= rb) ? rb - 1 : col_pos;
		have_above = (row_pos != 0);
		have_left  = (col >= bpp);
		a = have_left ? left_px[bpp - 1] : 8'h00;
		b = have_above ? prev_row[col] : 8'h00;
		c = (have_above && have_left) ? upleft_px[bpp - 1] : 8'h00;
		case (row_filt)
			FILT_SUB:   sum = raw + a;
			FILT_UP:    sum = raw + b;
			FILT_AVG:   sum = raw + ((a + 9'd0 + b) >> 1);
			FILT_PAETH: sum = raw + paeth_choose(a, b, c);
			default:    sum = raw;
		endcase
		val = sum[7:0];
		for (int i = 3; i > 0; i--) begin
			upleft_px[i] = upleft_px[i - 1];
			left_px[i]   = left_px[i - 1];
		end
		upleft_px[0]  = b;
		left_px[0]    = val;
		prev_row[col] = val;
		if (col + 1 >= rb) begin
			last_row = (row_pos + 1 >= rc);
			if (!image_bad)
				pending_pixels.push_back('{pixel: val, row_end: 1'b1, image_end: last_row,
					bad: 1'b0});
			want_filter = 1'b1;
			col_pos     = 0;
			if (last_row)
				restart_image();
			else
				row_pos = (row_pos + 1) & 12'hFFF;
		end else begin
			if (!image_bad)
				pending_pixels.push_back('{pixel: val, row_end: 1'b0, image_end: 1'b0,
					bad: 1'b0});
			col_pos = col + 1;
		end
	endtask

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			errors++;
			if (errors <= MAX_PRINTS)
				$display("%0t: %s mismatch, expected %02h actual %02h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_pixels.size() == 0) begin
				errors++;
				if (errors <= MAX_PRINTS)
					$display("%0t: unexpected item, expected none actual data %02h last %b user %b",
						$time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
			end else begin
				head_px = pending_pixels.pop_front();
				check_field("pixel_byte", head_px.pixel, m_axis_tdata);
				check_field("row_end", head_px.row_end, m_axis_tlast);
				check_field("image_end", head_px.image_end, m_axis_tuser[0]);
				check_field("bad_filter", head_px.bad, m_axis_tuser[1]);
			end
		end
	end

	// called and returns at a falling edge
	task automatic send_byte(logic [7:0] raw);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= raw;
		do @(posedge clk); while (!s_axis_tready);
		unfilter_byte(raw);
		sent_items++;
		@(negedge clk);
	endtask

	// filter bytes where a row starts, data bytes elsewhere
	task automatic send_stream(int n, int bad_pct);
		logic [7:0] raw;
		repeat (n) begin
			if (want_filter) begin
				if ($urandom_range(99) < bad_pct)
					raw = 8'($urandom_range(255, FILT_BAD_LOW));
				else
					raw = 8'($urandom_range(FILT_PAETH, FILT_NONE));
			end else begin
				case ($urandom_range(7))
					0:       raw = 8'h00;
					1:       raw = 8'hFF;
					default: raw = 8'($urandom());
				endcase
			end
			send_byte(raw);
		end
	endtask

	task automatic apb_write(logic [1:0] idx, logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		config_write(idx, data);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_idling(int src_pct, int snk_pct);
		src_idle_pct  = src_pct;
		snk_stall_pct = snk_pct;
	endtask

	// reset values: 4 bytes per row, 4 per pixel, one row
	task automatic test_default_regs();
		logic [7:0] img [10] = '{8'(FILT_NONE), 8'h00, 8'hFF, 8'h80, 8'h7F,
			8'(FILT_SUB), 8'h01, 8'hFF, 8'h02, 8'hFE};
		foreach (img[i])
			send_byte(img[i]);
		wait_idle();
	endtask

	task automatic test_each_filter();
		filt_t      kinds [5] = '{FILT_NONE, FILT_SUB, FILT_UP, FILT_AVG, FILT_PAETH};
		logic [7:0] rows [5][4] = '{
			'{8'hFF, 8'h01, 8'h80, 8'h7F},
			'{8'h10, 8'h20, 8'hF0, 8'hFF},
			'{8'hFF, 8'hFF, 8'h00, 8'h01},
			'{8'hFF, 8'h80, 8'hFF, 8'h01},
			'{8'h7F, 8'h80, 8'hFF, 8'h00}};
		apb_write(REG_ROW_BYTES, 32'd4);
		apb_write(REG_BPP, 32'd2);
		apb_write(REG_ROW_COUNT, 32'd5);
		foreach (kinds[r]) begin
			send_byte(8'(kinds[r]));
			for (int i = 0; i < 4; i++)
				send_byte(rows[r][i]);
		end
		wait_idle();
	endtask

	// error item, silent rest of image, clean restart after it
	task automatic test_bad_filter();
		apb_write(REG_ROW_BYTES, 32'd3);
		apb_write(REG_BPP, 32'd1);
		apb_write(REG_ROW_COUNT, 32'd3);
		send_byte(8'(FILT_SUB));
		send_byte(8'h05);
		send_byte(8'hFF);
		send_byte(8'h10);
		send_byte(FILT_BAD_LOW);
		send_stream(11, 0);
		send_byte(FILT_BAD_TOP);
		send_stream(11, 50);
		send_stream(12, 0);
		wait_idle();
	endtask

	task automatic test_register_writes();
		apb_write(REG_ROW_BYTES, 32'd5);
		apb_write(REG_BPP, 32'd3);
		apb_write(REG_ROW_COUNT, 32'd3);
		send_stream(9, 0);
		wait_idle();
		// unmapped address: no restart, row continues
		apb_write(REG_UNUSED, 32'hFFFF_FFFF);
		send_stream(13, 0);
		wait_idle();
		// mapped write mid-row restarts the image
		apb_write(REG_BPP, 32'd2);
		send_stream(18, 0);
		wait_idle();
	endtask

	task automatic test_register_extremes();
		apb_write(REG_ROW_BYTES, 32'd0);
		apb_write(REG_BPP, 32'd0);
		apb_write(REG_ROW_COUNT, 32'd0);
		send_stream(10, 10);
		wait_idle();
		// widest row: no early row end
		apb_write(REG_ROW_BYTES, 32'hFFFF_FFFF);
		apb_write(REG_BPP, 32'hFFFF_FFFF);
		apb_write(REG_ROW_COUNT, 32'd2);
		send_stream(EXTREME_ITEMS, 0);
		wait_idle();
		// most rows: no early image end
		apb_write(REG_ROW_BYTES, 32'd1);
		apb_write(REG_ROW_COUNT, 32'hFFFF_FFFF);
		send_stream(EXTREME_ITEMS, 0);
		wait_idle();
	endtask

	task automatic test_backpressure();
		apb_write(REG_ROW_BYTES, 32'd7);
		apb_write(REG_BPP, 32'd3);
		apb_write(REG_ROW_COUNT, 32'd4);
		@(posedge clk);
		hold_reqs++;
		@(negedge clk);
		send_stream(200, 5);
		wait_idle();
	endtask

	task automatic random_config();
		int unsigned rb;
		case ($urandom_range(9))
			0:       rb = 0;
			1:       rb = $urandom_range(64, 25);
			default: rb = $urandom_range(24, 1);
		endcase
		if ($urandom_range(3) != 0)
			apb_write(REG_ROW_BYTES, ($urandom() & 32'hFFFF_8000) | rb);
		if ($urandom_range(3) != 0)
			apb_write(REG_BPP, ($urandom() & 32'hFFFF_FFF8) | $urandom_range(7, 0));
		if ($urandom_range(3) != 0)
			apb_write(REG_ROW_COUNT, ($urandom() & 32'hFFFF_E000) | $urandom_range(6, 0));
	endtask

	task automatic test_random_stream(int n_items);
		int          goal;
		int unsigned total;
		bit          truncated;
		goal = sent_items + n_items;
		truncated = 1'b1;
		while (sent_items < goal) begin
			if (truncated || $urandom_range(2) != 0) begin
				wait_idle();
				random_config();
			end
			total = (clamp_reg(cfg_row_bytes, MAX_ROW_BYTES_DEF) + 1) *
				clamp_reg(cfg_row_count, MAX_ROWS_DEF);
			truncated = ($urandom_range(9) == 0);
			if (truncated)
				total = $urandom_range(total, 1);
			send_stream(total, 8);
		end
		wait_idle();
	endtask

	initial begin
		cfg_row_bytes = 15'd4;
		cfg_bpp       = 3'd4;
		cfg_row_count = 13'd1;
		restart_image();
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_idling(35, 35);
		test_default_regs();
		test_each_filter();
		test_bad_filter();
		test_register_writes();
		set_idling(0, 0);
		test_register_extremes();
		test_backpressure();

		set_idling(0, 0);
		test_random_stream(225);
		set_idling(65, 0);
		test_random_stream(225);
		set_idling(0, 65);
		test_random_stream(225);
		set_idling(35, 35);
		test_random_stream(225);

		wait_idle();
		if (errors == 0) begin
			$display("** png_scanline_unfilter: PASSED **");
		end else begin
			$display("** png_scanline_unfilter: FAILED **");
		end
		$finish;
	end

endmodule
`default_nettype wire

[sim.f]
hdl/pngu_pkg.sv
hdl/pngu_ram.sv
hdl/pngu_recon.sv
hdl/png_scanline_unfilter.sv
verif/png_scanline_unfilter_test.sv
